>>> hw/rtl/rolling_return_volatility_assert.svh
// assertion macros used by the top-level rtl file
`ifndef ROLLING_RETURN_VOLATILITY_ASSERT_SVH
`define ROLLING_RETURN_VOLATILITY_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define RRV_ASSERT_SAME(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("rolling_return_volatility: check failed");

// next-cycle implication, sampled on clk, off during reset
`define RRV_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("rolling_return_volatility: check failed");

`endif

>>> hw/rtl/rrv_pkg.sv
// package: widths, constants, state types and unit control structs
package rrv_pkg;

	localparam int WINDOW_DEF = 30;
	localparam int SERIES_DEF = 8;

	localparam int SER_W    = 3;
	localparam int PRICE_W  = 48;
	localparam int TIME_W   = 64;
	localparam int VOL_W    = 32;
	localparam int CNT_W    = 5;
	localparam int PERIOD_W = 40;
	localparam int LAG_W    = 32;
	localparam int SCALE_W  = 32;
	localparam int RET_W    = 32;
	localparam int RET_CNT_W = 5;
	localparam int RET_SCALE_W = 20;

	localparam int APB_AW = 5;
	localparam int APB_DW = 64;
	localparam int REG_IDX_LSB = 3;

	localparam logic [1:0] REG_PERIOD = 2'd0;
	localparam logic [1:0] REG_LAG    = 2'd1;
	localparam logic [1:0] REG_SCALE  = 2'd2;

	localparam logic [PERIOD_W-1:0] PERIOD_RST = 40'd60000000;
	localparam logic [LAG_W-1:0]    LAG_RST    = 32'd5000000;
	localparam logic [SCALE_W-1:0]  SCALE_RST  = 32'd39478572;
	localparam logic [VOL_W-1:0]    DEFAULT_VOL = 32'd600000;
	localparam logic [RET_SCALE_W-1:0] RET_SCALE = 20'd1000000;
	localparam logic [RET_W-1:0]    RET_MAX = 32'h7FFF_FFFF;
	localparam logic [RET_W-1:0]    RET_MIN = 32'h8000_0000;
	localparam int MIN_VOL_COUNT = 5;

	typedef struct packed {
		logic start;
	} unit_ctl_t;

	typedef struct packed {
		logic done;
	} unit_sts_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHECK,
		ST_P_RD,
		ST_P_DATA,
		ST_B_RD,
		ST_B_DATA,
		ST_RET_WAIT,
		ST_VOLCHK,
		ST_ACC,
		ST_NQ,
		ST_TSQ0,
		ST_TSQ1,
		ST_TSQ2,
		ST_DSUB,
		ST_DEV_GO,
		ST_DEV_WAIT,
		ST_RESULT
	} top_st_t;

	typedef enum logic [2:0] {
		RS_IDLE,
		RS_MUL,
		RS_CHK,
		RS_DIV,
		RS_SAT,
		RS_FIN
	} ret_st_t;

	typedef enum logic [2:0] {
		DS_IDLE,
		DS_DIV,
		DS_SQRT,
		DS_MUL0,
		DS_MUL1,
		DS_SUM,
		DS_FIN
	} dev_st_t;

endpackage

>>> hw/rtl/rrv_in_if.sv
// sample channel: valid, ready and the sample payload
interface rrv_in_if;
	import rrv_pkg::*;

	logic                valid;
	logic                ready;
	logic [SER_W-1:0]    series;
	logic [PRICE_W-1:0]  price;
	logic [TIME_W-1:0]   now_us;

	modport source (output valid, series, price, now_us, input ready);
	modport sink (input valid, series, price, now_us, output ready);
endinterface

>>> hw/rtl/rrv_out_if.sv
// result channel: valid, ready and the result payload
interface rrv_out_if;
	import rrv_pkg::*;

	logic              valid;
	logic              ready;
	logic [VOL_W-1:0]  volatility;
	logic [CNT_W-1:0]  sample_count;
	logic              appended;

	modport source (output valid, volatility, sample_count, appended, input ready);
	modport sink (input valid, volatility, sample_count, appended, output ready);
endinterface

>>> hw/rtl/rrv_ret.sv
// simple return unit: saturated 1e6*(price-prev)/prev by bit-serial division
module rrv_ret (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rrv_pkg::unit_ctl_t                 ctl,
	output rrv_pkg::unit_sts_t                 sts,
	input  logic [rrv_pkg::PRICE_W-1:0]        price,
	input  logic [rrv_pkg::PRICE_W-1:0]        prev,
	output logic signed [rrv_pkg::RET_W-1:0]   ret
);
	import rrv_pkg::*;

	localparam int NUM_W = PRICE_W + RET_SCALE_W;

	ret_st_t state_q, state_d;
	logic [RET_CNT_W-1:0] cnt_q;
	logic neg_q;
	logic [PRICE_W-1:0] diff_q;
	logic [PRICE_W-1:0] prev_q;
	logic [PRICE_W:0] rem_q;
	logic [RET_W-1:0] quo_q;
	logic [RET_W-1:0] ret_q;
	logic [NUM_W-1:0] num_c;
	logic [PRICE_W:0] remsh_c;
	logic ge_c;

	assign num_c = NUM_W'(diff_q) * NUM_W'(RET_SCALE);
	assign remsh_c = {rem_q[PRICE_W-1:0], quo_q[RET_W-1]};
	assign ge_c = remsh_c >= {1'b0, prev_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			RS_IDLE: begin
				if (ctl.start) begin
					state_d = (prev == '0) ? RS_FIN : RS_MUL;
				end
			end
			RS_MUL: state_d = RS_CHK;
			RS_CHK: state_d = (rem_q >= {1'b0, prev_q}) ? RS_FIN : RS_DIV;
			RS_DIV: begin
				if (cnt_q == RET_CNT_W'(RET_W - 1)) begin
					state_d = RS_SAT;
				end
			end
			RS_SAT: state_d = RS_FIN;
			RS_FIN: state_d = RS_IDLE;
			default: state_d = RS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RS_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= (state_d != state_q) ? '0 : cnt_q + RET_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			RS_IDLE: begin
				if (ctl.start) begin
					prev_q <= prev;
					neg_q <= price < prev;
					diff_q <= (price < prev) ? prev - price : price - prev;
					ret_q <= '0;
				end
			end
			RS_MUL: begin
				rem_q <= (PRICE_W + 1)'(num_c[NUM_W-1:RET_W]);
				quo_q <= num_c[RET_W-1:0];
			end
			RS_CHK: ret_q <= neg_q ? RET_MIN : RET_MAX;
			RS_DIV: begin
				rem_q <= ge_c ? remsh_c - {1'b0, prev_q} : remsh_c;
				quo_q <= {quo_q[RET_W-2:0], ge_c};
			end
			RS_SAT: begin
				if (neg_q) begin
					ret_q <= (quo_q > RET_MIN) ? RET_MIN : ~quo_q + RET_W'(1);
				end else begin
					ret_q <= quo_q[RET_W-1] ? RET_MAX : quo_q;
				end
			end
			default: ;
		endcase
	end

	assign sts.done = (state_q == RS_FIN);
	assign ret = ret_q;
endmodule

>>> hw/rtl/rrv_dev.sv
// deviation unit: divide by n(n-1), square root, annualise
module rrv_dev #(
	parameter int IW = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rrv_pkg::unit_ctl_t            ctl,
	output rrv_pkg::unit_sts_t            sts,
	input  logic [64+2*IW-1:0]            d,
	input  logic [IW-1:0]                 n,
	input  logic [rrv_pkg::SCALE_W-1:0]   scale,
	output logic [rrv_pkg::VOL_W-1:0]     vol
);
	import rrv_pkg::*;

	localparam int DW  = 64 + 2 * IW;
	localparam int NB  = DW + 32;
	localparam int MW  = 2 * IW;
	localparam int RW  = NB / 2;
	localparam int SRW = RW + 3;
	localparam int CW  = $clog2(NB);

	dev_st_t state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic [NB-1:0] x_q;
	logic [MW-1:0] m_q;
	logic [MW-1:0] rem_q;
	logic [SRW-1:0] sr_q;
	logic [RW-1:0] root_q;
	logic [63:0] p1_q;
	logic [RW-1:0] p2_q;
	logic [VOL_W-1:0] vol_q;
	logic [MW:0] remsh_c;
	logic [MW:0] dsub_c;
	logic dge_c;
	logic [SRW-1:0] sremsh_c;
	logic [SRW-1:0] trial_c;
	logic sge_c;
	logic [RW:0] sum_c;

	assign remsh_c = {rem_q, x_q[NB-1]};
	assign dsub_c = remsh_c - {1'b0, m_q};
	assign dge_c = remsh_c >= {1'b0, m_q};
	assign sremsh_c = {sr_q[SRW-3:0], x_q[NB-1:NB-2]};
	assign trial_c = SRW'({root_q, 2'b01});
	assign sge_c = sremsh_c >= trial_c;
	assign sum_c = (RW + 1)'(p2_q) + (RW + 1)'(p1_q[63:32]);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DS_IDLE: begin
				if (ctl.start) begin
					state_d = DS_DIV;
				end
			end
			DS_DIV: begin
				if (cnt_q == CW'(NB - 1)) begin
					state_d = DS_SQRT;
				end
			end
			DS_SQRT: begin
				if (cnt_q == CW'(RW - 1)) begin
					state_d = DS_MUL0;
				end
			end
			DS_MUL0: state_d = DS_MUL1;
			DS_MUL1: state_d = DS_SUM;
			DS_SUM: state_d = DS_FIN;
			DS_FIN: state_d = DS_IDLE;
			default: state_d = DS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DS_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= (state_d != state_q) ? '0 : cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			DS_IDLE: begin
				if (ctl.start) begin
					x_q <= {d, 32'b0};
					m_q <= MW'(MW'(n) * MW'(n - IW'(1)));
					rem_q <= '0;
					sr_q <= '0;
					root_q <= '0;
				end
			end
			DS_DIV: begin
				rem_q <= MW'(dge_c ? dsub_c : remsh_c);
				x_q <= {x_q[NB-2:0], dge_c};
			end
			DS_SQRT: begin
				sr_q <= sge_c ? sremsh_c - trial_c : sremsh_c;
				root_q <= {root_q[RW-2:0], sge_c};
				x_q <= {x_q[NB-3:0], 2'b00};
			end
			DS_MUL0: p1_q <= 64'(root_q[31:0]) * 64'(scale);
			DS_MUL1: p2_q <= RW'(RW'(root_q[RW-1:32]) * RW'(scale));
			DS_SUM: vol_q <= (|sum_c[RW:32]) ? '1 : sum_c[31:0];
			default: ;
		endcase
	end

	assign sts.done = (state_q == DS_FIN);
	assign vol = vol_q;
endmodule

>>> hw/rtl/rolling_return_volatility.sv
// top level: per-series return rings in memory, sequencer and register port
//
// samples (sink): series, price, now_us; a transfer at valid and ready high.
// results (source): volatility, sample_count, appended; one result per sample.
// apb port: sample_period at 0x00, early_lag at 0x08, vol_scale at 0x10,
// 64-bit data, pready always high; the user is to write only while the block
// is idle, which the block itself does not enforce. one sample is worked at
// a time; ready is high only between samples. the return unit (32-step
// divider) runs when a return is computed; with more than five prices
// held the ring sweep follows (one return read per cycle), then the sums,
// the bit-serial divide and the square root.
// the finished result waits in the output register; a new sample is taken
// while it waits, and a stalled receiver holds the next result back.
// reset clears the per-series heads, counts and times and loads register
// defaults; the ring memories are not cleared, only written entries are read.
`include "rolling_return_volatility_assert.svh"

module rolling_return_volatility #(
	parameter int WINDOW = rrv_pkg::WINDOW_DEF,
	parameter int SERIES = rrv_pkg::SERIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	rrv_in_if.sink                      samples,
	rrv_out_if.source                   results,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rrv_pkg::APB_AW-1:0]  paddr,
	input  logic [rrv_pkg::APB_DW-1:0]  pwdata,
	output logic [rrv_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);
	import rrv_pkg::*;

	localparam int IW    = $clog2(WINDOW);
	localparam int HW    = $clog2(WINDOW + 1);
	localparam int SW    = (SERIES > 1) ? $clog2(SERIES) : 1;
	localparam int DEPTH = SERIES * WINDOW;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int TW    = 32 + IW;
	localparam int QW    = 64 + IW;
	localparam int ABW   = 31 + IW;
	localparam int DW    = QW + IW;

	top_st_t state_q, state_d;

	logic [PERIOD_W-1:0] period_q;
	logic [LAG_W-1:0] lag_q;
	logic [SCALE_W-1:0] scale_q;

	logic [IW-1:0] head_q [SERIES];
	logic [HW-1:0] held_q [SERIES];
	logic [TIME_W-1:0] tlast_q [SERIES];

	logic [PRICE_W-1:0] price_mem [DEPTH];
	logic [RET_W-1:0] ret_mem [DEPTH];

	logic [SER_W-1:0] s_q;
	logic [PRICE_W-1:0] price_q;
	logic [TIME_W-1:0] now_q;
	logic [SW-1:0] s_idx;
	logic in_range_c;

	logic due_q;
	logic [IW-1:0] newest_q, slot_q, before_q, ret_idx_q;
	logic [HW-1:0] h_q;
	logic [AW-1:0] base_q;
	logic [AW-1:0] base_c;
	logic [IW-1:0] newest_c, slot_c, before_c;
	logic due_c;
	logic [IW+1:0] hd_ext, h_ext;
	logic [TIME_W:0] lhs_c, rhs_c;

	logic pw_en;
	logic [AW-1:0] pw_addr, pr_addr;
	logic [PRICE_W-1:0] pr_rd_q;
	logic rw_en;
	logic [AW-1:0] rw_addr, rr_addr;
	logic signed [RET_W-1:0] rr_rd_s1;

	logic [IW-1:0] iss_idx_q, iss_cnt_q, n_q;
	logic issuing_c;
	logic v_s1, v_s2;
	logic [RET_W-1:0] mag_c;
	logic [63:0] sq_s2;
	logic signed [RET_W-1:0] r_s2;
	logic signed [TW-1:0] t_q;
	logic [QW-1:0] q_q;
	logic [DW-1:0] nq_q, t2_q, d_q;
	logic [ABW-1:0] tabs_q;
	logic [19:0] mul_a, mul_b;
	logic [39:0] mp_c;

	logic [VOL_W-1:0] res_vol_q, out_vol_q;
	logic [CNT_W-1:0] res_cnt_q, out_cnt_q;
	logic res_app_q, out_app_q, out_valid_q;

	unit_ctl_t ret_ctl, dev_ctl;
	unit_sts_t ret_sts, dev_sts;
	logic signed [RET_W-1:0] ret_val;
	logic [VOL_W-1:0] dev_vol;
	logic cfg_wr;

	function automatic logic [IW-1:0] wrap_idx(input logic [IW+1:0] x);
		if (x >= (IW + 2)'(WINDOW)) begin
			return IW'(x - (IW + 2)'(WINDOW));
		end
		return IW'(x);
	endfunction

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
			lag_q <= LAG_RST;
			scale_q <= SCALE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[APB_AW-1:REG_IDX_LSB])
				REG_PERIOD: period_q <= pwdata[PERIOD_W-1:0];
				REG_LAG: lag_q <= pwdata[LAG_W-1:0];
				REG_SCALE: scale_q <= pwdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[APB_AW-1:REG_IDX_LSB])
			REG_PERIOD: prdata = APB_DW'(period_q);
			REG_LAG: prdata = APB_DW'(lag_q);
			REG_SCALE: prdata = APB_DW'(scale_q);
			default: prdata = '0;
		endcase
	end

	// ring position and due test for the held sample
	assign s_idx = SW'(s_q);
	assign base_c = AW'(32'(s_idx) * WINDOW);
	assign in_range_c = (32'(s_q) < SERIES);
	assign hd_ext = (IW + 2)'(head_q[s_idx]);
	assign h_ext = (IW + 2)'(held_q[s_idx]);
	assign newest_c = wrap_idx(hd_ext + h_ext - (IW + 2)'(1));
	assign before_c = wrap_idx(hd_ext + h_ext - (IW + 2)'(2));
	assign slot_c = (held_q[s_idx] >= HW'(WINDOW)) ? head_q[s_idx] : wrap_idx(hd_ext + h_ext);
	assign lhs_c = (TIME_W + 1)'(tlast_q[s_idx]) + (TIME_W + 1)'(period_q);
	assign rhs_c = (TIME_W + 1)'(now_q) + (TIME_W + 1)'(lag_q);
	assign due_c = lhs_c <= rhs_c;

	assign issuing_c = (state_q == ST_ACC) && (iss_cnt_q < n_q);
	assign mag_c = rr_rd_s1[RET_W-1] ? ~rr_rd_s1 + RET_W'(1) : rr_rd_s1;
	assign mp_c = 40'(mul_a) * 40'(mul_b);

	always_comb begin
		state_d = state_q;
		pw_en = 1'b0;
		pw_addr = base_q;
		pr_addr = base_q;
		rw_en = 1'b0;
		rw_addr = base_q + AW'(ret_idx_q);
		rr_addr = base_q + AW'(iss_idx_q);
		ret_ctl.start = 1'b0;
		dev_ctl.start = 1'b0;
		mul_a = tabs_q[19:0];
		mul_b = tabs_q[19:0];
		unique case (state_q)
			ST_IDLE: begin
				if (samples.valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!in_range_c) begin
					state_d = ST_RESULT;
				end else if (held_q[s_idx] == '0) begin
					pw_en = 1'b1;
					pw_addr = base_c;
					state_d = ST_VOLCHK;
				end else begin
					state_d = ST_P_RD;
				end
			end
			ST_P_RD: begin
				pr_addr = base_q + AW'(newest_q);
				state_d = ST_P_DATA;
			end
			ST_P_DATA: begin
				pw_en = 1'b1;
				if (due_q) begin
					pw_addr = base_q + AW'(slot_q);
					ret_ctl.start = 1'b1;
					state_d = ST_RET_WAIT;
				end else begin
					pw_addr = base_q + AW'(newest_q);
					state_d = (h_q > HW'(1)) ? ST_B_RD : ST_VOLCHK;
				end
			end
			ST_B_RD: begin
				pr_addr = base_q + AW'(before_q);
				state_d = ST_B_DATA;
			end
			ST_B_DATA: begin
				ret_ctl.start = 1'b1;
				state_d = ST_RET_WAIT;
			end
			ST_RET_WAIT: begin
				if (ret_sts.done) begin
					rw_en = 1'b1;
					state_d = ST_VOLCHK;
				end
			end
			ST_VOLCHK: begin
				state_d = (held_q[s_idx] > HW'(MIN_VOL_COUNT)) ? ST_ACC : ST_RESULT;
			end
			ST_ACC: begin
				if (!issuing_c && !v_s1 && !v_s2) begin
					state_d = ST_NQ;
				end
			end
			ST_NQ: state_d = ST_TSQ0;
			ST_TSQ0: state_d = ST_TSQ1;
			ST_TSQ1: begin
				mul_a = 20'(tabs_q[ABW-1:20]);
				state_d = ST_TSQ2;
			end
			ST_TSQ2: begin
				mul_a = 20'(tabs_q[ABW-1:20]);
				mul_b = 20'(tabs_q[ABW-1:20]);
				state_d = ST_DSUB;
			end
			ST_DSUB: state_d = ST_DEV_GO;
			ST_DEV_GO: begin
				dev_ctl.start = 1'b1;
				state_d = ST_DEV_WAIT;
			end
			ST_DEV_WAIT: begin
				if (dev_sts.done) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (!out_valid_q || results.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memories with registered read
	always_ff @(posedge clk) begin
		if (pw_en) begin
			price_mem[pw_addr] <= price_q;
		end
		pr_rd_q <= price_mem[pr_addr];
	end

	always_ff @(posedge clk) begin
		if (rw_en) begin
			ret_mem[rw_addr] <= ret_val;
		end
		rr_rd_s1 <= ret_mem[rr_addr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			iss_cnt_q <= '0;
			for (int i = 0; i < SERIES; i++) begin
				head_q[i] <= '0;
				held_q[i] <= '0;
				tlast_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			v_s1 <= issuing_c;
			v_s2 <= v_s1;
			if (state_q == ST_RESULT && (!out_valid_q || results.ready)) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CHECK: begin
					if (in_range_c && held_q[s_idx] == '0) begin
						head_q[s_idx] <= '0;
						held_q[s_idx] <= HW'(1);
						tlast_q[s_idx] <= now_q;
					end
				end
				ST_P_DATA: begin
					if (due_q) begin
						if (h_q >= HW'(WINDOW)) begin
							head_q[s_idx] <= wrap_idx(hd_ext + (IW + 2)'(1));
						end else begin
							held_q[s_idx] <= h_q + HW'(1);
						end
						tlast_q[s_idx] <= now_q;
					end
				end
				ST_VOLCHK: iss_cnt_q <= '0;
				ST_ACC: begin
					if (issuing_c) begin
						iss_cnt_q <= iss_cnt_q + IW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		sq_s2 <= 64'(mag_c) * 64'(mag_c);
		r_s2 <= rr_rd_s1;
		if (v_s2) begin
			t_q <= t_q + TW'(r_s2);
			q_q <= q_q + QW'(sq_s2);
		end
		unique case (state_q)
			ST_IDLE: begin
				s_q <= samples.series;
				price_q <= samples.price;
				now_q <= samples.now_us;
			end
			ST_CHECK: begin
				due_q <= due_c;
				newest_q <= newest_c;
				slot_q <= slot_c;
				before_q <= before_c;
				h_q <= held_q[s_idx];
				base_q <= base_c;
				res_vol_q <= DEFAULT_VOL;
				res_cnt_q <= '0;
				res_app_q <= in_range_c && (held_q[s_idx] == '0);
			end
			ST_P_DATA: begin
				res_app_q <= due_q;
				ret_idx_q <= due_q ? slot_q : newest_q;
			end
			ST_VOLCHK: begin
				res_cnt_q <= CNT_W'(held_q[s_idx]);
				iss_idx_q <= wrap_idx(hd_ext + (IW + 2)'(1));
				n_q <= IW'(held_q[s_idx] - HW'(1));
				t_q <= '0;
				q_q <= '0;
			end
			ST_ACC: begin
				if (issuing_c) begin
					iss_idx_q <= wrap_idx((IW + 2)'(iss_idx_q) + (IW + 2)'(1));
				end
			end
			ST_NQ: begin
				nq_q <= DW'(q_q) * DW'(n_q);
				tabs_q <= ABW'(t_q[TW-1] ? ~t_q + TW'(1) : t_q);
			end
			ST_TSQ0: t2_q <= DW'(mp_c);
			ST_TSQ1: t2_q <= t2_q + (DW'(mp_c) << 21);
			ST_TSQ2: t2_q <= t2_q + (DW'(mp_c) << 40);
			ST_DSUB: d_q <= nq_q - t2_q;
			ST_DEV_WAIT: begin
				if (dev_sts.done) begin
					res_vol_q <= dev_vol;
				end
			end
			ST_RESULT: begin
				if (!out_valid_q || results.ready) begin
					out_vol_q <= res_vol_q;
					out_cnt_q <= res_cnt_q;
					out_app_q <= res_app_q;
				end
			end
			default: ;
		endcase
	end

	rrv_ret u_ret (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ret_ctl),
		.sts    (ret_sts),
		.price  (price_q),
		.prev   (pr_rd_q),
		.ret    (ret_val)
	);

	rrv_dev #(
		.IW (IW)
	) u_dev (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (dev_ctl),
		.sts    (dev_sts),
		.d      (d_q),
		.n      (n_q),
		.scale  (scale_q),
		.vol    (dev_vol)
	);

	assign samples.ready = (state_q == ST_IDLE);
	assign results.valid = out_valid_q;
	assign results.volatility = out_vol_q;
	assign results.sample_count = out_cnt_q;
	assign results.appended = out_app_q;

	`RRV_ASSERT_NEXT(a_single_item, samples.valid && samples.ready, !samples.ready)
	`RRV_ASSERT_SAME(a_ret_done, ret_sts.done, state_q == ST_RET_WAIT)
	`RRV_ASSERT_SAME(a_dev_done, dev_sts.done, state_q == ST_DEV_WAIT)
	`RRV_ASSERT_SAME(a_held_bound, state_q == ST_VOLCHK, held_q[s_idx] <= HW'(WINDOW))
endmodule

>>> dv/rolling_return_volatility_test.sv
// testbench for rolling_return_volatility: directed and random samples checked against an in-bench predictor
`timescale 1ns / 100ps

module rolling_return_volatility_test;
	import rrv_pkg::*;

	localparam int WIN = 30;
	localparam int NSER = 8;
	localparam int LIMIT = 6000000;
	localparam int DRAIN = 300;
	localparam int QDEPTH = 2048;

	typedef struct packed {
		logic [SER_W-1:0]   series;
		logic [PRICE_W-1:0] price;
		logic [TIME_W-1:0]  now_us;
	} sample_t;

	typedef struct packed {
		logic [VOL_W-1:0] volatility;
		logic [CNT_W-1:0] sample_count;
		logic             appended;
	} vol_res_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	rrv_in_if samples_ch();
	rrv_out_if results_ch();

	rolling_return_volatility dut (
		.clk(clk), .arst_n(arst_n), .samples(samples_ch), .results(results_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	logic [PERIOD_W-1:0] cfg_period;
	logic [LAG_W-1:0]    cfg_lag;
	logic [SCALE_W-1:0]  cfg_scale;
	logic [PRICE_W-1:0]  price_mem [NSER][WIN];
	logic signed [31:0]  ret_mem [NSER][WIN];
	int                  head_of [NSER];
	int                  held_of [NSER];
	logic [TIME_W-1:0]   last_time [NSER];

	// stimulus state
	logic [TIME_W-1:0]  gen_time [NSER];
	logic [PRICE_W-1:0] gen_price [NSER];

	sample_t  pend_mem [QDEPTH];
	int       pend_wr = 0;
	int       pend_rd = 0;
	vol_res_t exp_mem [QDEPTH];
	int       exp_wr = 0;
	int       exp_rd = 0;
	int send_idle_pct, stall_pct;
	int mismatches;
	int cycles;
	bit in_took;

	function automatic logic signed [31:0] price_return(logic [47:0] p, logic [47:0] prev);
		logic [47:0] diff;
		logic [127:0] mag;
		logic [31:0] m32;
		if (prev == 0)
			return 0;
		diff = (p < prev) ? prev - p : p - prev;
		mag = ({80'd0, diff} * 128'd1000000) / {80'd0, prev};
		if (p < prev) begin
			if (mag > 128'h8000_0000)
				mag = 128'h8000_0000;
			m32 = mag[31:0];
			return -m32;
		end
		if (mag > 128'h7FFF_FFFF)
			mag = 128'h7FFF_FFFF;
		return mag[31:0];
	endfunction

	function automatic logic [31:0] deviation_of(int s);
		int h, n;
		logic signed [63:0] t, r;
		logic [127:0] q, d, w, m, quo, root, c, p, tabs, ra;
		h = held_of[s];
		n = h - 1;
		t = 0;
		q = 0;
		for (int k = 1; k < h; k++) begin
			r = ret_mem[s][(head_of[s] + k) % WIN];
			t += r;
			ra = (r < 0) ? -r : r;
			q += ra * ra;
		end
		tabs = (t < 0) ? -t : t;
		d = q * n - tabs * tabs;
		w = d << 32;
		m = n * (n - 1);
		quo = w / m;
		root = 0;
		for (int i = 55; i >= 0; i--) begin
			c = root | (128'd1 << i);
			if (c * c <= quo)
				root = c;
		end
		p = (root * cfg_scale) >> 32;
		if (p > 128'hFFFF_FFFF)
			return 32'hFFFF_FFFF;
		return p[31:0];
	endfunction

	function automatic vol_res_t vol_step(sample_t it);
		vol_res_t res;
		int s, h, hd, newest, slot;
		logic [64:0] lhs, rhs;
		logic [47:0] prev;
		s = it.series;
		h = held_of[s];
		hd = head_of[s];
		res.appended = 0;
		if (h == 0) begin
			head_of[s] = 0;
			price_mem[s][0] = it.price;
			held_of[s] = 1;
			last_time[s] = it.now_us;
			res.appended = 1;
		end else begin
			lhs = {1'b0, last_time[s]} + {25'd0, cfg_period};
			rhs = {1'b0, it.now_us} + {33'd0, cfg_lag};
			newest = (hd + h - 1) % WIN;
			if (lhs <= rhs) begin
				prev = price_mem[s][newest];
				if (h >= WIN) begin
					slot = hd;
					head_of[s] = (hd + 1) % WIN;
				end else begin
					slot = (hd + h) % WIN;
					held_of[s] = h + 1;
				end
				price_mem[s][slot] = it.price;
				ret_mem[s][slot] = price_return(it.price, prev);
				last_time[s] = it.now_us;
				res.appended = 1;
			end else begin
				price_mem[s][newest] = it.price;
				if (h > 1)
					ret_mem[s][newest] = price_return(it.price,
						price_mem[s][(hd + h - 2) % WIN]);
			end
		end
		res.sample_count = CNT_W'(held_of[s]);
		res.volatility = (held_of[s] > MIN_VOL_COUNT) ? deviation_of(s) : DEFAULT_VOL;
		return res;
	endfunction

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// input transfer and prediction, result checking, cycle limit
	always @(posedge clk) begin
		vol_res_t want;
		cycles++;
		if (cycles > LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
		in_took = samples_ch.valid && samples_ch.ready;
		if (in_took) begin
			exp_mem[exp_wr] = vol_step({samples_ch.series, samples_ch.price,
				samples_ch.now_us});
			exp_wr++;
		end
		if (results_ch.valid && results_ch.ready) begin
			if (exp_wr == exp_rd) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result vol=%0d cnt=%0d app=%0d",
						results_ch.volatility, results_ch.sample_count, results_ch.appended);
			end else begin
				want = exp_mem[exp_rd];
				exp_rd++;
				if (results_ch.volatility !== want.volatility ||
					results_ch.sample_count !== want.sample_count ||
					results_ch.appended !== want.appended) begin
					mismatches++;
					if (mismatches <= 10)
						$display("expected vol=%0d cnt=%0d app=%0d, got vol=%0d cnt=%0d app=%0d",
							want.volatility, want.sample_count, want.appended,
							results_ch.volatility, results_ch.sample_count,
							results_ch.appended);
				end
			end
		end
	end

	// sample driver
	always @(negedge clk) begin
		sample_t it;
		if (arst_n && (!samples_ch.valid || in_took)) begin
			if (pend_wr != pend_rd && $urandom_range(99) >= send_idle_pct) begin
				it = pend_mem[pend_rd];
				pend_rd++;
				samples_ch.valid <= 1'b1;
				samples_ch.series <= it.series;
				samples_ch.price <= it.price;
				samples_ch.now_us <= it.now_us;
			end else begin
				samples_ch.valid <= 1'b0;
			end
		end
	end

	// result receiver
	always @(negedge clk)
		results_ch.ready <= arst_n && ($urandom_range(99) >= stall_pct);

	task automatic reg_write(logic [1:0] idx, logic [63:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_PERIOD: cfg_period = val[PERIOD_W-1:0];
			REG_LAG: cfg_lag = val[LAG_W-1:0];
			REG_SCALE: cfg_scale = val[SCALE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pend_wr != pend_rd || samples_ch.valid || exp_wr != exp_rd)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic add(int s, logic [47:0] p, logic [63:0] t);
		pend_mem[pend_wr] = {s[SER_W-1:0], p, t};
		pend_wr++;
	endtask

	// random walk with occasional extremes, times around the due threshold
	task automatic add_random();
		int s, k;
		logic [63:0] thr, dt;
		logic [47:0] p, step;
		s = $urandom_range(NSER - 1);
		thr = (cfg_period > cfg_lag) ? cfg_period - cfg_lag : 0;
		case ($urandom_range(19))
			0, 1, 2, 3, 4, 5, 6, 7, 8: dt = thr + 64'($urandom_range(1000));
			9, 10: dt = thr;
			11, 12: dt = (thr > 0) ? thr - 1 : 0;
			13, 14, 15: dt = 64'($urandom_range(1000));
			16: dt = {$urandom, $urandom};
			17: dt = thr * 2;
			default: dt = ({$urandom, $urandom} % (thr + 1));
		endcase
		gen_time[s] += dt;
		if ($urandom_range(49) == 0)
			gen_time[s] = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(3);
		p = gen_price[s];
		k = $urandom_range(19);
		if (k == 0)
			p = 0;
		else if (k == 1)
			p = 48'({$urandom, $urandom});
		else if (k == 2)
			p = 48'hFFFF_FFFF_FFFF;
		else if (k == 3)
			p = 48'($urandom_range(5) + 1);
		else begin
			if (p == 0)
				p = 48'd1000000;
			step = (p >> $urandom_range(12, 3)) + 48'($urandom_range(3));
			if ($urandom_range(1))
				p = (p > step) ? p - step : p;
			else
				p = (p + step < p) ? p : p + step;
		end
		gen_price[s] = p;
		add(s, p, gen_time[s]);
	endtask

	initial begin
		logic [63:0] t;
		mismatches = 0;
		cycles = 0;
		in_took = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		cfg_period = PERIOD_RST;
		cfg_lag = LAG_RST;
		cfg_scale = SCALE_RST;
		for (int s = 0; s < NSER; s++) begin
			head_of[s] = 0;
			held_of[s] = 0;
			last_time[s] = 0;
			gen_time[s] = {$urandom, $urandom} >> 2;
			gen_price[s] = 48'd1000000 + $urandom_range(1000000);
		end
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		samples_ch.valid = 0;
		samples_ch.series = 0;
		samples_ch.price = 0;
		samples_ch.now_us = 0;
		results_ch.ready = 0;
		arst_n = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: first sample, rising window, zero and extreme prices
		t = 0;
		add(0, 48'd1000000, t);
		add(1, 48'd5000000, 64'd10);
		add(1, 48'd6000000, 64'd20);
		for (int i = 0; i < 8; i++) begin
			t += 64'd55000000;
			case (i)
				2: add(0, 0, t);
				3: add(0, 48'hFFFF_FFFF_FFFF, t);
				4: add(0, 48'd1, t);
				default: add(0, 48'd1000000 + i * 13000, t);
			endcase
		end
		add(0, 48'd2000000, t + 5);
		add(0, 0, t + 6);
		add(2, 48'd7, 64'hFFFF_FFFF_FFFF_FFF0);
		add(2, 48'd9, 64'hFFFF_FFFF_FFFF_FFFF);
		add(3, 48'hFFFF_FFFF_FFFF, 64'd0);
		add(3, 48'd0, 64'd55000000);
		add(3, 48'd3, 64'd110000000);
		add(4, 48'hFFFF_FFFF_FFFF, 64'd100);
		add(4, 48'hFFFF_FFFF_FFFF, 64'd100);
		add(7, 48'd123456789, 64'd5);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0; stall_pct = 0;
				end
				1: begin
					reg_write(REG_PERIOD, 64'd1000);
					reg_write(REG_LAG, 64'd0);
					reg_write(REG_SCALE, 64'hFFFF_FFFF);
					send_idle_pct = 71; stall_pct = 0;
				end
				2: begin
					reg_write(REG_PERIOD, 64'd0);
					reg_write(REG_LAG, 64'hFFFF_FFFF);
					reg_write(REG_SCALE, 64'd0);
					send_idle_pct = 0; stall_pct = 71;
				end
				3: begin
					reg_write(REG_PERIOD, 64'hFF_FFFF_FFFF);
					reg_write(REG_LAG, 64'd0);
					reg_write(REG_SCALE, 64'd65536);
					send_idle_pct = 7; stall_pct = 7;
				end
				default: begin
					reg_write(REG_PERIOD, 64'd5000);
					reg_write(REG_LAG, 64'd4000);
					reg_write(REG_SCALE, SCALE_RST);
					send_idle_pct = 0; stall_pct = 0;
				end
			endcase
			for (int i = 0; i < 326; i++) begin
				add_random();
				// pause in phase 1 until every result is back
				if (i == 160 && ph == 1) begin
					while (pend_wr != pend_rd || samples_ch.valid || exp_wr != exp_rd)
						@(posedge clk);
				end
			end
			while (pend_wr != pend_rd)
				@(posedge clk);
			drain();
		end

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
